@@ rtl/core/tdm_pkg.sv @@
// Shared constants and register codes for the tank drive mixer.
`default_nettype none

package tdm_pkg;

    // Configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE    = 3'd0,
        CFG_SPEED_LEVEL = 3'd1,
        CFG_MULT_HIGH   = 3'd2,
        CFG_MULT_MID    = 3'd3,
        CFG_MULT_LOW    = 3'd4,
        CFG_LEFT_GAIN   = 3'd5,
        CFG_RIGHT_GAIN  = 3'd6
    } cfg_reg_t;

    // Speed level codes; any other level selects the low multiplier
    localparam logic [1:0] LEVEL_HIGH = 2'd3;
    localparam logic [1:0] LEVEL_MID  = 2'd2;

    localparam logic [6:0] DEADZONE_RESET    = 7'd5;
    localparam logic [1:0] SPEED_LEVEL_RESET = 2'd2;

    // Full scale drive in percent and the quotient width that holds it
    localparam int         QBITS   = 7;
    localparam logic [6:0] PCT_MAX = 7'd100;

endpackage

`default_nettype wire

@@ rtl/core/tank_drive_mix_normalize.sv @@
// One word per cycle sustained while the result port does not stall.
// Stages: deadzone and speed multiply, gain multiply, max select, dividend,
// seven restoring division steps for the ratio normalization, output register.
// A stall at the result port holds every full stage in place; empty stages still load, so bubbles are filled first.
// Reset (synchronous, aresetn low) empties the pipeline and loads register defaults.
`default_nettype none

module tank_drive_mix_normalize #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [7:0]                   s_left_cmd,
    input  wire logic signed [7:0]                   s_right_cmd,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [7:0]                        m_left_out,
    output logic signed [7:0]                        m_right_out,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tdm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [((GAIN_FRAC_BITS+1 > 7) ? GAIN_FRAC_BITS+1 : 7)-1:0] cfg_data
);
    import tdm_pkg::*;

    localparam int F   = GAIN_FRAC_BITS;
    localparam int MW  = F + 1;            // multiplier and gain width
    localparam int M1W = 8 + MW;           // command times multiplier
    localparam int PW  = M1W + MW;         // full side product
    localparam int DW  = PW + QBITS;       // dividend, 100 times the smaller side
    localparam int N   = QBITS + 5;        // pipeline stages
    localparam logic [PW-1:0] LIMIT = PW'(100) << (2 * F);

    localparam logic [MW-1:0] MULT_HIGH_RESET = MW'(1) << F;
    localparam logic [MW-1:0] MULT_MID_RESET  = MW'(3) << (F - 2);
    localparam logic [MW-1:0] MULT_LOW_RESET  = MW'(1) << (F - 1);
    localparam logic [MW-1:0] GAIN_RESET      = MW'(1) << F;

    typedef struct packed {
        logic       l_neg;
        logic       r_neg;
        logic       left_max;
        logic       norm;
        logic [6:0] plain_l;
        logic [6:0] plain_r;
    } side_t;

    typedef struct packed {
        logic [M1W-1:0] l_p;
        logic [M1W-1:0] r_p;
        logic           l_neg;
        logic           r_neg;
    } st1_t;

    typedef struct packed {
        logic [PW-1:0] lm;
        logic [PW-1:0] rm;
        logic          l_neg;
        logic          r_neg;
    } st2_t;

    typedef struct packed {
        logic [PW-1:0] mx;
        logic [PW-1:0] mn;
        side_t         side;
    } st3_t;

    typedef struct packed {
        logic [DW-1:0]    rem;
        logic [PW-1:0]    den;
        logic [QBITS-1:0] q;
        side_t            side;
    } div_t;

    // Configuration registers
    logic [6:0]    deadzone_reg;
    logic [1:0]    speed_level_reg;
    logic [MW-1:0] mult_high_reg, mult_mid_reg, mult_low_reg;
    logic [MW-1:0] left_gain_reg, right_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg    <= DEADZONE_RESET;
            speed_level_reg <= SPEED_LEVEL_RESET;
            mult_high_reg   <= MULT_HIGH_RESET;
            mult_mid_reg    <= MULT_MID_RESET;
            mult_low_reg    <= MULT_LOW_RESET;
            left_gain_reg   <= GAIN_RESET;
            right_gain_reg  <= GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEADZONE:    deadzone_reg    <= cfg_data[6:0];
                CFG_SPEED_LEVEL: speed_level_reg <= cfg_data[1:0];
                CFG_MULT_HIGH:   mult_high_reg   <= cfg_data[MW-1:0];
                CFG_MULT_MID:    mult_mid_reg    <= cfg_data[MW-1:0];
                CFG_MULT_LOW:    mult_low_reg    <= cfg_data[MW-1:0];
                CFG_LEFT_GAIN:   left_gain_reg   <= cfg_data[MW-1:0];
                CFG_RIGHT_GAIN:  right_gain_reg  <= cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when it is empty or drains
    logic [N-1:0] v_reg, v_next, en;

    always_comb begin
        en[N-1] = !v_reg[N-1] || m_ready;
        for (int i = N - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int i = 1; i < N; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[N-1];

    // Stage 1: deadzone, sign split, speed multiplier
    st1_t          st1_reg, st1_next;
    logic [7:0]    l_raw, r_raw, l_mag, r_mag;
    logic          l_keep, r_keep;
    logic [MW-1:0] mult;

    always_comb begin
        case (speed_level_reg)
            LEVEL_HIGH: mult = mult_high_reg;
            LEVEL_MID:  mult = mult_mid_reg;
            default:    mult = mult_low_reg;
        endcase
        l_raw  = s_left_cmd;
        r_raw  = s_right_cmd;
        l_mag  = l_raw[7] ? 8'(~l_raw + 8'd1) : l_raw;
        r_mag  = r_raw[7] ? 8'(~r_raw + 8'd1) : r_raw;
        l_keep = (l_mag >= {1'b0, deadzone_reg});
        r_keep = (r_mag >= {1'b0, deadzone_reg});
        st1_next.l_p   = l_keep ? (M1W'(l_mag) * M1W'(mult)) : '0;
        st1_next.r_p   = r_keep ? (M1W'(r_mag) * M1W'(mult)) : '0;
        st1_next.l_neg = l_raw[7] && l_keep;
        st1_next.r_neg = r_raw[7] && r_keep;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            st1_reg <= st1_next;
        end
    end

    // Stage 2: side correction gain
    st2_t st2_reg, st2_next;

    always_comb begin
        st2_next.lm    = PW'(st1_reg.l_p) * PW'(left_gain_reg);
        st2_next.rm    = PW'(st1_reg.r_p) * PW'(right_gain_reg);
        st2_next.l_neg = st1_reg.l_neg;
        st2_next.r_neg = st1_reg.r_neg;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            st2_reg <= st2_next;
        end
    end

    // Stage 3: pick the larger side, flag normalization, unscaled percent
    st3_t st3_reg, st3_next;

    always_comb begin
        st3_next.side.left_max = (st2_reg.lm >= st2_reg.rm);
        st3_next.mx = st3_next.side.left_max ? st2_reg.lm : st2_reg.rm;
        st3_next.mn = st3_next.side.left_max ? st2_reg.rm : st2_reg.lm;
        st3_next.side.norm    = (st3_next.mx > LIMIT);
        // without normalization both sides are at most 100 after the shift
        st3_next.side.plain_l = st2_reg.lm[2*F +: 7];
        st3_next.side.plain_r = st2_reg.rm[2*F +: 7];
        st3_next.side.l_neg   = st2_reg.l_neg;
        st3_next.side.r_neg   = st2_reg.r_neg;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            st3_reg <= st3_next;
        end
    end

    // Stage 4 and the division steps
    div_t divs_reg  [QBITS+1];
    div_t divs_next [QBITS+1];

    always_comb begin
        divs_next[0].rem  = (DW'(st3_reg.mn) << 6) + (DW'(st3_reg.mn) << 5)
                          + (DW'(st3_reg.mn) << 2);
        divs_next[0].den  = st3_reg.mx;
        divs_next[0].q    = '0;
        divs_next[0].side = st3_reg.side;
    end

    genvar k;
    generate
        for (k = 0; k < QBITS; k++) begin : g_div
            tdm_div_step #(
                .DW (DW),
                .PW (PW),
                .K  (QBITS - 1 - k)
            ) u_step (
                .rem_in  (divs_reg[k].rem),
                .den     (divs_reg[k].den),
                .q_in    (divs_reg[k].q),
                .rem_out (divs_next[k+1].rem),
                .q_out   (divs_next[k+1].q)
            );
            assign divs_next[k+1].den  = divs_reg[k].den;
            assign divs_next[k+1].side = divs_reg[k].side;
        end

        for (k = 0; k <= QBITS; k++) begin : g_div_reg
            always_ff @(posedge aclk) begin
                if (en[3+k]) begin
                    divs_reg[k] <= divs_next[k];
                end
            end
        end
    endgenerate

    // Output stage: if normalizing, larger side gives full scale, smaller the quotient; else plain percent
    logic [7:0] out_l_reg, out_r_reg, out_l_next, out_r_next;
    logic [6:0] mag_l, mag_r;
    side_t      fin;

    always_comb begin
        fin = divs_reg[QBITS].side;
        if (fin.norm) begin
            mag_l = fin.left_max ? PCT_MAX : divs_reg[QBITS].q;
            mag_r = fin.left_max ? divs_reg[QBITS].q : PCT_MAX;
        end else begin
            mag_l = fin.plain_l;
            mag_r = fin.plain_r;
        end
        out_l_next = fin.l_neg ? 8'(~{1'b0, mag_l} + 8'd1) : {1'b0, mag_l};
        out_r_next = fin.r_neg ? 8'(~{1'b0, mag_r} + 8'd1) : {1'b0, mag_r};
    end

    always_ff @(posedge aclk) begin
        if (en[N-1]) begin
            out_l_reg <= out_l_next;
            out_r_reg <= out_r_next;
        end
    end

    assign m_left_out  = out_l_reg;
    assign m_right_out = out_r_reg;

endmodule

`default_nettype wire

@@ rtl/core/tdm_div_step.sv @@
// One restoring division step: decides one quotient bit of rem / den.
`default_nettype none

module tdm_div_step #(
    parameter int DW = 33,
    parameter int PW = 26,
    parameter int K  = 0
) (
    input  wire logic [DW-1:0]              rem_in,
    input  wire logic [PW-1:0]              den,
    input  wire logic [tdm_pkg::QBITS-1:0]  q_in,
    output logic      [DW-1:0]              rem_out,
    output logic      [tdm_pkg::QBITS-1:0]  q_out
);
    import tdm_pkg::*;

    logic [DW-1:0] trial;
    logic          ge;

    always_comb begin
        trial   = DW'(den) << K;
        ge      = (rem_in >= trial);
        rem_out = ge ? (rem_in - trial) : rem_in;
        q_out   = q_in;
        q_out[K] = ge;
    end

endmodule

`default_nettype wire
